// ===== design/psc_pkg.sv =====
// Shared types and constants for the per-stream packet sequence checker.
`default_nettype none
package psc_pkg;

  localparam logic [1:0] MODE_PACKET = 2'd0;
  localparam logic [1:0] MODE_INIT   = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;

  localparam logic [1:0] FRAG_MIDDLE = 2'd0;
  localparam logic [1:0] FRAG_BEGIN  = 2'd1;
  localparam logic [1:0] FRAG_END    = 2'd2;
  localparam logic [1:0] FRAG_SINGLE = 2'd3;

  localparam logic [1:0] ST_OK            = 2'd0;
  localparam logic [1:0] ST_BAD_ID        = 2'd1;
  localparam logic [1:0] ST_MISMATCH      = 2'd2;
  localparam logic [1:0] ST_NOT_STREAMING = 2'd3;

  localparam logic [15:0] FIRST_PKT_ID = 16'd1;
  localparam int unsigned MASK_BITS = 16;

  // indexed [previous][next]
  localparam logic [3:0] FRAG_ALLOWED [4] = '{4'b0101, 4'b0101, 4'b1010, 4'b1010};

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] stream_id;
    logic [15:0] packet_id;
    logic [15:0] msg_type;
    logic [1:0]  frag_flags;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       forward;
    logic       loss_flag;
    logic       id_gap;
    logic       frag_error;
  } out_word_t;

  typedef struct packed {
    logic [15:0] expected_id;
    logic [1:0]  last_frag;
    logic [15:0] frame_msg_type;
    logic        loss_seen;
  } ctx_t;

  typedef struct packed {
    logic in_range;
    logic enabled;
  } strm_info_t;

endpackage
`default_nettype wire

// ===== design/psc_ctx_update.sv =====
// Per-stream context update and result generation for one word.
`default_nettype none
module psc_ctx_update (
  input  psc_pkg::in_word_t   item_i,
  input  psc_pkg::ctx_t       ctx_i,
  input  psc_pkg::strm_info_t info_i,
  output psc_pkg::ctx_t       ctx_o,
  output logic                we_o,
  output psc_pkg::out_word_t  res_o
);
  import psc_pkg::*;

  logic gap, ferr, loss_a, loss_b, mism;

  always_comb begin
    gap    = item_i.packet_id != ctx_i.expected_id;
    loss_a = ctx_i.loss_seen | gap;
    ferr   = !loss_a && !FRAG_ALLOWED[ctx_i.last_frag][item_i.frag_flags];
    loss_b = loss_a | ferr;
    mism   = !item_i.frag_flags[0] && !loss_b && (item_i.msg_type != ctx_i.frame_msg_type);
  end

  always_comb begin
    res_o = '0;
    ctx_o = ctx_i;
    we_o  = 1'b0;
    priority if (item_i.mode != MODE_PACKET && item_i.mode != MODE_INIT &&
                 item_i.mode != MODE_CLEAR) begin
      res_o = '0;
    end else if (!info_i.in_range) begin
      res_o.status = ST_BAD_ID;
    end else if (item_i.mode == MODE_INIT) begin
      we_o  = 1'b1;
      ctx_o = '{expected_id: FIRST_PKT_ID, last_frag: FRAG_END,
                frame_msg_type: '0, loss_seen: 1'b0};
    end else if (item_i.mode == MODE_CLEAR) begin
      we_o            = 1'b1;
      ctx_o.loss_seen = 1'b0;
    end else begin
      we_o                 = 1'b1;
      ctx_o.expected_id    = item_i.packet_id + 16'd1;
      ctx_o.last_frag      = item_i.frag_flags;
      ctx_o.frame_msg_type = item_i.frag_flags[0] ? item_i.msg_type : ctx_i.frame_msg_type;
      ctx_o.loss_seen      = loss_b | mism;
      res_o.id_gap         = gap;
      res_o.frag_error     = ferr;
      res_o.loss_flag      = loss_b | mism;
      res_o.forward        = !mism && info_i.enabled;
      priority if (mism) begin
        res_o.status = ST_MISMATCH;
      end else if (!info_i.enabled) begin
        res_o.status = ST_NOT_STREAMING;
      end else begin
        res_o.status = ST_OK;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/per_stream_packet_sequence_checker.sv =====
// Top level: per-stream packet sequence and fragment checker with context memory.
//
//   channel | direction | handshake              | word
//   in      | input     | in_valid_i / in_stall_o  | psc_pkg::in_word_t
//   out     | output    | out_valid_o / out_stall_i | psc_pkg::out_word_t
//   cfg     | input     | cfg_we_i                | 16-bit stream enable mask
//
// One word per cycle sustained while the output is not stalled; the result becomes valid when
// the word leaves the update stage (context memory read at accept, then update, write-back and
// output register). Back-to-back words to one stream are served by forwarding the last
// write-back. Reset clears per-entry valid bits at once; no clearing pass. A stalled output
// register holds the update stage, which stalls input.
`default_nettype none
module per_stream_packet_sequence_checker #(
  parameter int unsigned STREAM_COUNT = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  psc_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output psc_pkg::out_word_t  out_word_o,
  input  logic                cfg_we_i,
  input  logic [15:0]         cfg_wdata_i
);
  import psc_pkg::*;

  localparam int unsigned AW = (STREAM_COUNT > 1) ? $clog2(STREAM_COUNT) : 1;

  ctx_t              ctx_mem [STREAM_COUNT];
  ctx_t              rd_q;
  logic [STREAM_COUNT-1:0] vld_q;
  logic [15:0]       mask_q;

  in_word_t          s1_item_q;
  logic              s1_valid_q;
  logic              wr_vld_q;
  logic [AW-1:0]     wr_addr_q;
  ctx_t              wr_data_q;
  logic              out_valid_q;
  out_word_t         out_word_q;

  logic              in_accept, s1_adv, mem_we, upd_we;
  logic [AW-1:0]     in_addr, s1_addr;
  ctx_t              ctx_cur, ctx_new;
  strm_info_t        info;
  out_word_t         res;

  assign in_addr    = in_word_i.stream_id[AW-1:0];
  assign s1_addr    = s1_item_q.stream_id[AW-1:0];
  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign mem_we     = s1_adv && upd_we;

  always_comb begin
    if (wr_vld_q && wr_addr_q == s1_addr) begin
      ctx_cur = wr_data_q;
    end else if (vld_q[s1_addr]) begin
      ctx_cur = rd_q;
    end else begin
      ctx_cur = '0;
    end
    info.in_range = {1'b0, s1_item_q.stream_id} < 17'(STREAM_COUNT);
    info.enabled  = (s1_item_q.stream_id[15:4] == 12'd0) &&
                    mask_q[s1_item_q.stream_id[3:0]];
  end

  psc_ctx_update u_upd (
    .item_i (s1_item_q),
    .ctx_i  (ctx_cur),
    .info_i (info),
    .ctx_o  (ctx_new),
    .we_o   (upd_we),
    .res_o  (res)
  );

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      rd_q <= ctx_mem[in_addr];
    end
    if (mem_we) begin
      ctx_mem[s1_addr] <= ctx_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      mask_q      <= '0;
      s1_valid_q  <= 1'b0;
      wr_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mask_q <= cfg_wdata_i;
      end
      if (mem_we) begin
        vld_q[s1_addr] <= 1'b1;
        wr_vld_q       <= 1'b1;
      end
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_word_i;
    end
    if (mem_we) begin
      wr_addr_q <= s1_addr;
      wr_data_q <= ctx_new;
    end
    if (s1_adv) begin
      out_word_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  a_stall_needs_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled without a blocked update stage");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> s1_valid_q)
    else $error("accepted word lost before update stage");

  a_bad_id_dropped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.status == ST_BAD_ID |-> !out_word_o.forward)
    else $error("word with bad stream id forwarded");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> info.in_range && s1_adv)
    else $error("context write for out-of-range stream");

endmodule
`default_nettype wire
